[design/assert_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define KILT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define KILT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[design/kilt_pkg.sv]
// Package with sizes, codes and types of the keyed item list table.
`default_nettype none

package kilt_pkg;

    localparam int MAX_OWNERS      = 16;
    localparam int ITEMS_PER_OWNER = 16;
    localparam int KEY_W           = 16;
    localparam int ITEM_W          = 16;

    localparam int OWNER_AW   = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int OWNER_CW   = $clog2(MAX_OWNERS + 1);
    localparam int LEN_W      = $clog2(ITEMS_PER_OWNER + 1);
    localparam int ITEM_DEPTH = MAX_OWNERS * ITEMS_PER_OWNER;
    localparam int ITEM_AW    = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
    localparam int SCAN_W     = (OWNER_CW > LEN_W) ? OWNER_CW : LEN_W;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (2 + ITEM_W + 1);

    // The spare code is answered like a query.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_USE    = 2'd1,
        OP_QUERY  = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OSCAN,
        S_INSERT,
        S_ISCAN,
        S_SH_RD,
        S_SH_WR,
        S_USE_WB,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } owner_row_t;

endpackage

`default_nettype wire

[design/keyed_item_list_table.sv]
// Top level of the keyed item list table.
//
// Each input word carries an operation on one owner (insert an item, remove an item,
// or ask whether its list is empty) and produces exactly one result word. Owners sit
// in an owner RAM (key and list length) and list entries in an item RAM, both with a
// single registered read port, so the block works on one word at a time.
// A word is accepted, then the owner search reads the owner slots one by one, up to
// the match for a known owner and over all owners otherwise. An insert adds a write
// step and a query nothing more. A remove adds the item search over the list entries
// up to the match, then shifts each later entry down by a read and a write, and ends
// with a last read step and a write-back of the owner row. The result then passes to
// the output register. A finished result waits in the output register, and the next
// word is accepted while it waits; a word whose result is ready stalls while the
// previous result is still waiting.
// The stores hold no reset contents: nothing is read before it is written.
`default_nettype none

module keyed_item_list_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // owner_key [15:0], item_code [31:16]
    input  logic [kilt_pkg::IN_TDATA_W-1:0]     s_tdata,
    // op [1:0]
    input  logic [kilt_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [1:0], removed_item [17:2], owner_empty [18], zero [23:19]
    output logic [kilt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    import kilt_pkg::*;

    fsm_t                state_reg, state_next;
    logic [OWNER_CW-1:0] owner_total_reg, owner_total_next;
    logic [1:0]          op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ITEM_W-1:0]   code_reg, code_next;
    logic [SCAN_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [SCAN_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [OWNER_AW-1:0] slot_reg, slot_next;
    logic [ITEM_AW-1:0]  base_reg, base_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                new_owner_reg, new_owner_next;
    logic [SCAN_W-1:0]   pos_reg, pos_next;
    status_t             res_status_reg, res_status_next;
    logic [ITEM_W-1:0]   res_removed_reg, res_removed_next;
    logic                res_empty_reg, res_empty_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ITEM_W-1:0]   out_removed_reg, out_removed_next;
    logic                out_empty_reg, out_empty_next;

    logic                owner_wr_en;
    logic [OWNER_AW-1:0] owner_wr_addr;
    owner_row_t          owner_wr_data;
    logic                owner_rd_en;
    logic [OWNER_AW-1:0] owner_rd_addr;
    owner_row_t          owner_rd_data;

    logic                item_wr_en;
    logic [ITEM_AW-1:0]  item_wr_addr;
    logic [ITEM_W-1:0]   item_wr_data;
    logic                item_rd_en;
    logic [ITEM_AW-1:0]  item_rd_addr;
    logic [ITEM_W-1:0]   item_rd_data;

    logic                is_insert;
    logic                is_use;
    logic                owner_hit;
    logic                owner_more;
    logic                item_hit;
    logic                item_more;
    logic [SCAN_W:0]     pos_inc;
    logic                shift_more;
    logic                table_full;
    logic                list_full;
    logic [LEN_W-1:0]    len_dec;
    logic                out_free;

    kilt_ram #(
        .DEPTH (MAX_OWNERS),
        .WIDTH ($bits(owner_row_t))
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (owner_wr_en),
        .wr_addr (owner_wr_addr),
        .wr_data (owner_wr_data),
        .rd_en   (owner_rd_en),
        .rd_addr (owner_rd_addr),
        .rd_data (owner_rd_data)
    );

    kilt_ram #(
        .DEPTH (ITEM_DEPTH),
        .WIDTH (ITEM_W)
    ) u_item_ram (
        .clk     (clk),
        .wr_en   (item_wr_en),
        .wr_addr (item_wr_addr),
        .wr_data (item_wr_data),
        .rd_en   (item_rd_en),
        .rd_addr (item_rd_addr),
        .rd_data (item_rd_data)
    );

    // Op code three falls through to the query path.
    assign is_insert  = (op_reg == OP_INSERT);
    assign is_use     = (op_reg == OP_USE);

    // A compare is pending for the slot read in the previous cycle.
    assign owner_hit  = pend_reg && (owner_rd_data.key == key_reg);
    assign owner_more = (scan_idx_reg < SCAN_W'(owner_total_reg));
    assign item_hit   = pend_reg && (item_rd_data == code_reg);
    assign item_more  = (scan_idx_reg < SCAN_W'(len_reg));
    assign pos_inc    = {1'b0, pos_reg} + 1'b1;
    assign shift_more = (pos_inc < (SCAN_W + 1)'(len_reg));
    assign table_full = (owner_total_reg >= OWNER_CW'(MAX_OWNERS));
    assign list_full  = (len_reg >= LEN_W'(ITEMS_PER_OWNER));
    assign len_dec    = len_reg - 1'b1;
    assign out_free   = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_empty_reg, out_removed_reg, out_status_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_OSCAN;
                end
            end
            S_OSCAN:
            begin
                if (owner_hit)
                begin
                    if (is_insert)
                    begin
                        state_next = S_INSERT;
                    end
                    else if (is_use)
                    begin
                        state_next = S_ISCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!owner_more)
                begin
                    state_next = (is_insert && !table_full) ? S_INSERT : S_DONE;
                end
            end
            S_INSERT:
            begin
                state_next = S_DONE;
            end
            S_ISCAN:
            begin
                if (item_hit)
                begin
                    state_next = S_SH_RD;
                end
                else if (!item_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_SH_RD:
            begin
                state_next = shift_more ? S_SH_WR : S_USE_WB;
            end
            S_SH_WR:
            begin
                state_next = S_SH_RD;
            end
            S_USE_WB:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        owner_total_next = owner_total_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        code_next        = code_reg;
        scan_idx_next    = scan_idx_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        slot_next        = slot_reg;
        base_next        = base_reg;
        len_next         = len_reg;
        new_owner_next   = new_owner_reg;
        pos_next         = pos_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        res_empty_next   = res_empty_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_empty_next   = out_empty_reg;

        owner_wr_en   = 1'b0;
        owner_wr_addr = slot_reg;
        owner_wr_data = '{key: key_reg, len: len_reg};
        owner_rd_en   = 1'b0;
        owner_rd_addr = scan_idx_reg[OWNER_AW-1:0];
        item_wr_en    = 1'b0;
        item_wr_addr  = ITEM_AW'(32'(base_reg) + 32'(len_reg));
        item_wr_data  = code_reg;
        item_rd_en    = 1'b0;
        item_rd_addr  = ITEM_AW'(32'(base_reg) + 32'(scan_idx_reg));

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next          = s_tuser[1:0];
                    key_next         = s_tdata[KEY_W-1:0];
                    code_next        = s_tdata[KEY_W+ITEM_W-1:KEY_W];
                    scan_idx_next    = '0;
                    pend_next        = 1'b0;
                    res_status_next  = ST_OK;
                    res_removed_next = '0;
                    res_empty_next   = 1'b1;
                end
            end
            S_OSCAN:
            begin
                pend_next = 1'b0;
                if (owner_hit)
                begin
                    slot_next      = pend_idx_reg[OWNER_AW-1:0];
                    base_next      = ITEM_AW'(32'(pend_idx_reg) * ITEMS_PER_OWNER);
                    len_next       = owner_rd_data.len;
                    new_owner_next = 1'b0;
                    scan_idx_next  = '0;
                    res_empty_next = (owner_rd_data.len == '0);
                end
                else if (owner_more)
                begin
                    owner_rd_en   = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (is_insert)
                begin
                    if (table_full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        slot_next      = owner_total_reg[OWNER_AW-1:0];
                        base_next      = ITEM_AW'(32'(owner_total_reg) * ITEMS_PER_OWNER);
                        len_next       = '0;
                        new_owner_next = 1'b1;
                    end
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                end
            end
            S_INSERT:
            begin
                if (list_full)
                begin
                    res_status_next = ST_FULL;
                    res_empty_next  = (len_reg == '0);
                end
                else
                begin
                    item_wr_en       = 1'b1;
                    owner_wr_en      = 1'b1;
                    owner_wr_data    = '{key: key_reg, len: LEN_W'(len_reg + 1'b1)};
                    res_empty_next   = 1'b0;
                    if (new_owner_reg)
                    begin
                        owner_total_next = owner_total_reg + 1'b1;
                    end
                end
            end
            S_ISCAN:
            begin
                pend_next = 1'b0;
                if (item_hit)
                begin
                    pos_next = pend_idx_reg;
                end
                else if (item_more)
                begin
                    item_rd_en    = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_empty_next  = (len_reg == '0);
                end
            end
            S_SH_RD:
            begin
                if (shift_more)
                begin
                    item_rd_en   = 1'b1;
                    item_rd_addr = ITEM_AW'(32'(base_reg) + 32'(pos_inc));
                end
            end
            S_SH_WR:
            begin
                // The entry after pos was read in the previous cycle.
                item_wr_en   = 1'b1;
                item_wr_addr = ITEM_AW'(32'(base_reg) + 32'(pos_reg));
                item_wr_data = item_rd_data;
                pos_next     = pos_inc[SCAN_W-1:0];
            end
            S_USE_WB:
            begin
                owner_wr_en      = 1'b1;
                owner_wr_data    = '{key: key_reg, len: len_dec};
                res_status_next  = ST_OK;
                res_removed_next = code_reg;
                res_empty_next   = (len_dec == '0);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_removed_next = res_removed_reg;
                    out_empty_next   = res_empty_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            owner_total_reg <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            owner_total_reg <= owner_total_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        code_reg        <= code_next;
        scan_idx_reg    <= scan_idx_next;
        pend_idx_reg    <= pend_idx_next;
        slot_reg        <= slot_next;
        base_reg        <= base_next;
        len_reg         <= len_next;
        new_owner_reg   <= new_owner_next;
        pos_reg         <= pos_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        res_empty_reg   <= res_empty_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_empty_reg   <= out_empty_next;
    end

endmodule

`default_nettype wire

[design/kilt_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module kilt_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/kilt_checker.sv]
// Port-level assertions for the keyed item list table and their bind statement.
`default_nettype none

`include "assert_macros.svh"

module kilt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [kilt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    import kilt_pkg::*;

    logic [1:0]        res_status;
    logic [ITEM_W-1:0] res_removed;
    logic              in_accept;
    logic              out_stall;
    logic              item_out;

    assign res_status  = m_tdata[1:0];
    assign res_removed = m_tdata[ITEM_W+1:2];
    assign in_accept   = s_tvalid && s_tready;
    assign out_stall   = m_tvalid && !m_tready;
    assign item_out    = m_tvalid && (res_removed != '0);

    // A result word that waits keeps its contents.
    `KILT_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Only a successful remove returns an item.
    `KILT_ASSERT(a_removed_ok, item_out |-> (res_status == ST_OK), "item returned without ok status")

    // One word is worked on at a time.
    `KILT_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready, "input accepted while busy")

    // A new result is only produced by a word in progress.
    `KILT_ASSERT(a_result_from_work, $rose(m_tvalid) |-> $past(!s_tready), "result with no word")

endmodule

bind keyed_item_list_table kilt_checker u_kilt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the keyed item list table, with a stream driver and a result monitor.
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import kilt_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_WORDS = 1030;

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic [ITEM_W-1:0] code;
    } table_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ITEM_W-1:0] removed;
        logic              empty;
    } table_resp_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    keyed_item_list_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the owner table.
    logic [OWNER_CW-1:0] tbl_total;
    logic [KEY_W-1:0]    tbl_keys  [MAX_OWNERS];
    logic [LEN_W-1:0]    tbl_len   [MAX_OWNERS];
    logic [ITEM_W-1:0]   tbl_items [ITEM_DEPTH];

    table_cmd_t  pending_words[$];
    table_resp_t expected_results[$];
    table_cmd_t  cur_cmd;

    int words_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int n_removed = 0;
    int n_list_full = 0;
    int n_table_full = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int quiet = 0;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic table_resp_t table_apply(input table_cmd_t cmd);
        table_resp_t r;
        int slot;
        int len;
        int pos;
        int base;
        r.status  = ST_OK;
        r.removed = '0;
        r.empty   = 1'b1;
        slot = -1;
        for (int i = 0; i < int'(tbl_total); i++)
        begin
            if (slot < 0 && tbl_keys[i] == cmd.key)
                slot = i;
        end
        if (cmd.op == OP_INSERT)
        begin
            if (slot < 0)
            begin
                if (int'(tbl_total) >= MAX_OWNERS)
                begin
                    r.status = ST_FULL;
                    n_table_full++;
                end
                else
                begin
                    slot = int'(tbl_total);
                    tbl_keys[slot] = cmd.key;
                    tbl_len[slot]  = '0;
                    tbl_total      = tbl_total + 1'b1;
                end
            end
            if (slot >= 0)
            begin
                len = int'(tbl_len[slot]);
                if (len >= ITEMS_PER_OWNER)
                begin
                    r.status = ST_FULL;
                    n_list_full++;
                end
                else
                begin
                    tbl_items[slot * ITEMS_PER_OWNER + len] = cmd.code;
                    tbl_len[slot] = LEN_W'(len + 1);
                end
                r.empty = (tbl_len[slot] == 0);
            end
        end
        else if (cmd.op == OP_USE)
        begin
            if (slot < 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                base = slot * ITEMS_PER_OWNER;
                len  = int'(tbl_len[slot]);
                pos  = len;
                for (int i = len - 1; i >= 0; i--)
                begin
                    if (tbl_items[base + i] == cmd.code)
                        pos = i;
                end
                if (pos >= len)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // Close the gap left by the first matching entry.
                    for (int i = pos; i + 1 < len; i++)
                        tbl_items[base + i] = tbl_items[base + i + 1];
                    tbl_len[slot] = LEN_W'(len - 1);
                    r.removed = cmd.code;
                    n_removed++;
                end
                r.empty = (tbl_len[slot] == 0);
            end
        end
        else
        begin
            // Op code three behaves as a query.
            if (slot < 0)
                r.status = ST_NOT_FOUND;
            else
                r.empty = (tbl_len[slot] == 0);
        end
        return r;
    endfunction

    // Driver: presents queued words and records what each accepted one should produce.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
            tbl_total = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(table_apply(cur_cmd));
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_cmd = pending_words.pop_front();
                    s_tdata  <= {cur_cmd.code, cur_cmd.key};
                    s_tuser  <= cur_cmd.op;
                    s_tvalid <= 1'b1;
                    send_gap <= $urandom_range(0, 4);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: takes result words with random back-pressure and checks them in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 2;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result word 0x%h arrived with nothing expected", m_tdata);
                    errors++;
                end
                else
                begin
                    table_resp_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (m_tdata[1:0] !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[17:2] !== exp_r.removed)
                    begin
                        $error("removed_item: expected 0x%h, got 0x%h",
                               exp_r.removed, m_tdata[17:2]);
                        errors++;
                    end
                    if (m_tdata[18] !== exp_r.empty)
                    begin
                        $error("owner_empty: expected %0d, got %0d", exp_r.empty, m_tdata[18]);
                        errors++;
                    end
                end
                begin
                    int d;
                    d = $urandom_range(0, 4);
                    m_tready   <= (d == 0);
                    recv_stall <= d;
                end
            end
            else if (!m_tready)
            begin
                if (recv_stall <= 1)
                    m_tready <= 1'b1;
                else
                    recv_stall <= recv_stall - 1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Timeout after %0d idle cycles", quiet);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic [1:0] op, input logic [15:0] key,
                              input logic [15:0] code);
        table_cmd_t c;
        c.op   = op;
        c.key  = key;
        c.code = code;
        pending_words.push_back(c);
    endtask

    initial
    begin
        logic [KEY_W-1:0]  key_pool  [20];
        logic [ITEM_W-1:0] item_pool [8];
        logic [KEY_W-1:0]  k;
        int burst;
        int run;
        int queued;

        rst_n = 1'b0;

        // Unknown owners, extreme keys and items, duplicates and removal down to empty.
        queue_word(OP_QUERY, 16'h1234, 16'h0000);
        queue_word(OP_USE,   16'h1234, 16'h0001);
        queue_word(OP_SPARE, 16'h1234, 16'hFFFF);
        queue_word(OP_INSERT, 16'h0000, 16'h0000);
        queue_word(OP_INSERT, 16'hFFFF, 16'hFFFF);
        queue_word(OP_INSERT, 16'hFFFF, 16'hFFFF);
        queue_word(OP_INSERT, 16'hFFFF, 16'h5A5A);
        queue_word(OP_QUERY, 16'hFFFF, 16'h0000);
        queue_word(OP_USE,   16'hFFFF, 16'h0001);
        queue_word(OP_USE,   16'hFFFF, 16'hFFFF);
        queue_word(OP_USE,   16'hFFFF, 16'hFFFF);
        queue_word(OP_USE,   16'hFFFF, 16'h5A5A);
        queue_word(OP_QUERY, 16'hFFFF, 16'hFFFF);
        queue_word(OP_USE,   16'hFFFF, 16'h5A5A);
        queue_word(OP_USE,   16'h0000, 16'h0000);
        queue_word(OP_SPARE, 16'h0000, 16'h0000);
        queue_word(OP_INSERT, 16'h0000, 16'hA5A5);
        queue_word(OP_SPARE, 16'h0000, 16'h0000);

        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 20; i++)
            key_pool[i] = 16'($urandom);
        item_pool[0] = 16'h0000;
        item_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            item_pool[i] = 16'($urandom);

        // Bursts on a handful of owners reach full lists and, with more keys
        // than slots, a full owner table.
        queued = 0;
        while (queued < RANDOM_WORDS)
        begin
            burst = $urandom_range(0, 9);
            k = key_pool[$urandom_range(0, 19)];
            run = $urandom_range(1, 20);
            for (int j = 0; j < run; j++)
            begin
                if (burst <= 3)
                    queue_word(2'($urandom_range(0, 3)), key_pool[$urandom_range(0, 19)],
                               item_pool[$urandom_range(0, 7)]);
                else if (burst <= 5)
                    queue_word(OP_INSERT, k, item_pool[$urandom_range(0, 7)]);
                else if (burst <= 7)
                    queue_word(OP_USE, k, item_pool[$urandom_range(0, 7)]);
                else if (burst == 8)
                    queue_word(2'($urandom_range(2, 3)), key_pool[$urandom_range(0, 19)],
                               16'($urandom));
                else
                    queue_word(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
            end
            queued += run;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d words and checked %0d results over the insert, use and query paths.",
                 words_sent, results_seen);
        $display("Removals: %0d, full-list rejects: %0d, full-table rejects: %0d.",
                 n_removed, n_list_full, n_table_full);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
